FILE: design/aplm_pkg.sv
// ----------------------------------------------------------------------------
// Audio peak level meter package
// Shared sizes, request and register codes, tick sequencer states and the
// logarithmic display curve, which is built at elaboration.
// ----------------------------------------------------------------------------
package aplm_pkg;

   // Channel storage and index sizes.
   localparam int MAX_CHANNELS = 8;
   localparam int CH_IDX_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_W        = $clog2(MAX_CHANNELS + 1);

   // Field widths of the ports.
   localparam int REQ_TYPE_W = 2;
   localparam int CHAN_W     = 3;
   localparam int SAMPLE_W   = 16;
   localparam int PEAK_W     = 15;
   localparam int LEVEL_W    = 16;
   localparam int NUM_CH_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Register reset values.
   localparam logic [NUM_CH_W-1:0] NUM_CH_RESET = NUM_CH_W'(2);
   localparam logic [LEVEL_W-1:0]  DECAY_RESET  = LEVEL_W'(328);
   localparam logic                LOG_MODE_RESET = 1'b1;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_SAMPLE   = 2'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_SNAPSHOT = 2'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK     = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANNELS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOG_MODE     = 2'd2;

   // Display tick sequencer states.
   typedef enum logic [2:0] {
      TICK_IDLE,
      TICK_READ,
      TICK_LOOK,
      TICK_CALC,
      TICK_SEND
   } tick_state_type;

   // Log curve table sizes.
   localparam int LOG_ENTRIES = 1024;
   localparam int LOG_IDX_W   = $clog2(LOG_ENTRIES);
   localparam logic [63:0] LOG_DEN = 64'(LOG_ENTRIES - 1);

   typedef logic [LEVEL_W-1:0] curve_type [LOG_ENTRIES];

   // Log2 in Q.32 from an integer part and a Q1.31 mantissa in [1,2),
   // refined one fraction bit per squaring.
   function automatic logic [63:0] log2_frac(input logic [63:0] ip, input logic [63:0] mant);
      logic [63:0] m;
      logic [63:0] res;
      m   = mant;
      res = ip << 32;
      for (int b = 31; b >= 0; b--) begin
         m = (m * m) >> 31;
         if (m >= (64'd2 << 31)) begin
            m      = m >> 1;
            res[b] = 1'b1;
         end
      end
      return res;
   endfunction

   // Log2 of ten: integer part three, mantissa 10/8.
   localparam logic [63:0] LOG2_TEN = log2_frac(64'd3, (64'd10 << 31) >> 3);

   // Entry i is 65535*log10(1 + 9*i/(entries-1)), rounded.
   function automatic curve_type build_curve();
      curve_type   t;
      logic [63:0] num;
      logic [63:0] ip;
      logic [63:0] m;
      logic [63:0] l;
      logic [63:0] v;
      for (int i = 0; i < LOG_ENTRIES; i++) begin
         num = LOG_DEN + 64'd9 * 64'(i);
         ip  = 64'd0;
         for (int k = 0; k < 8; k++) begin
            if (num >= (LOG_DEN << (ip + 64'd1))) begin
               ip = ip + 64'd1;
            end
         end
         m = ((num << 31) >> ip) / LOG_DEN;
         l = log2_frac(ip, m);
         v = (64'd65535 * l + LOG2_TEN / 2) / LOG2_TEN;
         t[LOG_IDX_W'(i)] = (v > 64'd65535) ? 16'hFFFF : v[LEVEL_W-1:0];
      end
      return t;
   endfunction

   localparam curve_type LOG_CURVE = build_curve();

endpackage

FILE: design/aplm_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual port RAM
// One write port and one read port; read data is registered, and a read
// of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module aplm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/audio_peak_level_meter_unit.sv
// Sample beats: one per cycle unless the request side stalls; read-modify-write
// of the peak RAM through the s1 stage, forwarding when the same channel follows
// back to back. Snapshots swap the running and pending banks if samples arrived,
// else empty the running bank. Display tick: stalls requests through read, curve
// lookup, compute and send per channel in use, and while results stall. Reset:
// synchronous; peaks and levels read as zero at once through valid bits.
// ----------------------------------------------------------------------------
// Audio peak level meter
// Multichannel peak tracking with snapshot and a per-channel display level
// that follows a log or linear curve on new data and decays otherwise.
// ----------------------------------------------------------------------------
module audio_peak_level_meter_unit
   import aplm_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [REQ_TYPE_W-1:0]        req_type,
   input  logic [CHAN_W-1:0]            req_chan_index,
   input  logic signed [SAMPLE_W-1:0]   req_sample_value,
   // Response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [CHAN_W-1:0]            rsp_out_channel,
   output logic [LEVEL_W-1:0]           rsp_display_level,
   output logic                         rsp_fresh,
   output logic                         rsp_last,
   // Register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int PK_AW = CH_IDX_W + 1;

   // Configuration registers.
   logic [NUM_CH_W-1:0] num_ch_ff;
   logic [LEVEL_W-1:0]  decay_ff;
   logic                log_mode_ff;

   // Bank and flag state.
   logic                   run_bank_ff;
   logic                   seen_ff;
   logic                   pend_vld_ff;
   logic [1:0][MAX_CHANNELS-1:0] pk_vld_ff;
   logic [1:0][MAX_CHANNELS-1:0] pk_vld_in;
   logic [MAX_CHANNELS-1:0] disp_vld_ff;

   // Sample update stage.
   logic              s1_vld_ff;
   logic [PK_AW-1:0]  s1_addr_ff;
   logic [PEAK_W-1:0] s1_mag_ff;
   logic              s1_fwd_ff;
   logic [PEAK_W-1:0] s1_fwd_val_ff;
   logic [PEAK_W-1:0] s1_old;
   logic [PEAK_W-1:0] s1_new;

   // Tick sequencer.
   tick_state_type      state_ff;
   tick_state_type      state_in;
   logic [CH_IDX_W-1:0] tick_ch_ff;
   logic                tick_read;
   logic                tick_look;
   logic                tick_calc;
   logic                tick_send;
   logic [LEVEL_W-1:0]  curve_ff;

   // Output registers.
   logic                rsp_valid_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic                rsp_fresh_ff;
   logic                rsp_last_ff;

   // Request decode.
   logic [CNT_W-1:0]    n_act;
   logic                req_take;
   logic                smp_take;
   logic                snap_take;
   logic                tick_take;
   logic [CH_IDX_W-1:0] req_ch;
   logic [PK_AW-1:0]    req_addr;
   logic [SAMPLE_W-1:0] abs_val;
   logic [PEAK_W-1:0]   req_mag;
   logic                tick_last;
   logic                rsp_take;

   // Memory ports.
   logic [PK_AW-1:0]    pk_rd_addr;
   logic [PEAK_W-1:0]   pk_rd_data;
   logic [LEVEL_W-1:0]  disp_rd_data;
   logic [PEAK_W-1:0]   pend_peak;
   logic [LEVEL_W-1:0]  old_level;
   logic [LEVEL_W-1:0]  new_level;

   // Active channel count, clamped to the supported range.
   always_comb begin
      if (num_ch_ff == '0) begin
         n_act = CNT_W'(1);
      end else if (int'(num_ch_ff) > MAX_CHANNELS) begin
         n_act = CNT_W'(MAX_CHANNELS);
      end else begin
         n_act = CNT_W'(num_ch_ff);
      end
   end

   // Request acceptance and sample magnitude, saturated to full scale.
   assign req_take  = req_valid && !req_stall;
   assign req_ch    = CH_IDX_W'(req_chan_index);
   assign req_addr  = {run_bank_ff, req_ch};
   assign smp_take  = req_take && (req_type == REQ_SAMPLE)
                      && (int'(req_chan_index) < int'(n_act));
   assign snap_take = req_take && (req_type == REQ_SNAPSHOT);
   assign tick_take = req_take && (req_type == REQ_TICK);
   assign abs_val   = req_sample_value[SAMPLE_W-1] ? (~req_sample_value + 16'd1)
                                                   : req_sample_value;
   assign req_mag   = abs_val[SAMPLE_W-1] ? {PEAK_W{1'b1}} : abs_val[PEAK_W-1:0];

   // Peak update: forwarded value, stored value, or zero when the entry is not valid.
   always_comb begin
      if (s1_fwd_ff) begin
         s1_old = s1_fwd_val_ff;
      end else if (pk_vld_ff[s1_addr_ff[PK_AW-1]][s1_addr_ff[CH_IDX_W-1:0]]) begin
         s1_old = pk_rd_data;
      end else begin
         s1_old = '0;
      end
      s1_new = (s1_mag_ff > s1_old) ? s1_mag_ff : s1_old;
   end

   // Peak valid bits: a snapshot with new data empties the old pending bank,
   // which becomes the running bank; otherwise it empties the running bank.
   // A peak write marks its entry.
   always_comb begin
      pk_vld_in = pk_vld_ff;
      if (snap_take) begin
         if (seen_ff) begin
            pk_vld_in[~run_bank_ff] = '0;
         end else begin
            pk_vld_in[run_bank_ff] = '0;
         end
      end
      if (s1_vld_ff) begin
         pk_vld_in[s1_addr_ff[PK_AW-1]][s1_addr_ff[CH_IDX_W-1:0]] = 1'b1;
      end
   end

   // Peak RAM read address: the tick reads the pending bank and holds the
   // address through the curve lookup.
   assign pk_rd_addr = tick_read ? {~run_bank_ff, tick_ch_ff} : req_addr;

   aplm_ram #(
      .WIDTH(PEAK_W),
      .DEPTH(2 * MAX_CHANNELS)
   ) u_peak_ram (
      .clock  (clock),
      .wr_en  (s1_vld_ff),
      .wr_addr(s1_addr_ff),
      .wr_data(s1_new),
      .rd_addr(pk_rd_addr),
      .rd_data(pk_rd_data)
   );

   aplm_ram #(
      .WIDTH(LEVEL_W),
      .DEPTH(MAX_CHANNELS)
   ) u_level_ram (
      .clock  (clock),
      .wr_en  (tick_calc),
      .wr_addr(tick_ch_ff),
      .wr_data(new_level),
      .rd_addr(tick_ch_ff),
      .rd_data(disp_rd_data)
   );

   // Display level of the current channel.
   always_comb begin
      pend_peak = pk_vld_ff[~run_bank_ff][tick_ch_ff] ? pk_rd_data : '0;
      old_level = disp_vld_ff[tick_ch_ff] ? disp_rd_data : '0;
      if (pend_vld_ff) begin
         if (log_mode_ff) begin
            new_level = curve_ff;
         end else begin
            new_level = {pend_peak, 1'b0};
         end
      end else if (old_level > decay_ff) begin
         new_level = old_level - decay_ff;
      end else begin
         new_level = '0;
      end
   end

   assign tick_last = (CNT_W'(tick_ch_ff) + CNT_W'(1)) == n_act;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         TICK_IDLE: begin
            if (tick_take) begin
               state_in = TICK_READ;
            end
         end
         TICK_READ: begin
            state_in = TICK_LOOK;
         end
         TICK_LOOK: begin
            state_in = TICK_CALC;
         end
         TICK_CALC: begin
            state_in = TICK_SEND;
         end
         TICK_SEND: begin
            if (rsp_take) begin
               state_in = rsp_last_ff ? TICK_IDLE : TICK_READ;
            end
         end
         default: begin
            state_in = TICK_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = 1'b1;
      tick_read = 1'b0;
      tick_look = 1'b0;
      tick_calc = 1'b0;
      tick_send = 1'b0;
      unique case (state_ff)
         TICK_IDLE: req_stall = 1'b0;
         TICK_READ: tick_read = 1'b1;
         TICK_LOOK: begin
            tick_read = 1'b1;
            tick_look = 1'b1;
         end
         TICK_CALC: tick_calc = 1'b1;
         TICK_SEND: tick_send = 1'b1;
         default:   req_stall = 1'b1;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ch_ff    <= NUM_CH_RESET;
         decay_ff     <= DECAY_RESET;
         log_mode_ff  <= LOG_MODE_RESET;
         run_bank_ff  <= 1'b0;
         seen_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
         pk_vld_ff    <= '0;
         disp_vld_ff  <= '0;
         s1_vld_ff    <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         state_ff     <= TICK_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ch_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         pk_vld_ff <= pk_vld_in;

         // Register writes.
         if (csr_valid) begin
            unique case (csr_index)
               CSR_NUM_CHANNELS: num_ch_ff   <= csr_data[NUM_CH_W-1:0];
               CSR_DECAY_STEP:   decay_ff    <= csr_data[LEVEL_W-1:0];
               CSR_LOG_MODE:     log_mode_ff <= csr_data[0];
               default:          num_ch_ff   <= num_ch_ff;
            endcase
         end

         // Sample stage; forward when the same entry is written this cycle.
         s1_vld_ff <= smp_take;
         s1_fwd_ff <= smp_take && s1_vld_ff && (s1_addr_ff == req_addr);

         // Snapshot swaps banks if anything arrived; the new running bank
         // starts empty.
         if (snap_take) begin
            seen_ff <= 1'b0;
            if (seen_ff) begin
               run_bank_ff <= ~run_bank_ff;
               pend_vld_ff <= 1'b1;
            end
         end else if (smp_take) begin
            seen_ff <= 1'b1;
         end

         // Tick sequencing.
         if (tick_take) begin
            tick_ch_ff <= '0;
         end
         if (tick_calc) begin
            disp_vld_ff[tick_ch_ff] <= 1'b1;
            rsp_valid_ff            <= 1'b1;
         end
         if (tick_send && rsp_take) begin
            rsp_valid_ff <= 1'b0;
            if (rsp_last_ff) begin
               pend_vld_ff <= 1'b0;
            end else begin
               tick_ch_ff <= tick_ch_ff + CH_IDX_W'(1);
            end
         end
      end
   end

   // Payload registers and the registered curve lookup.
   always_ff @(posedge clock) begin
      if (smp_take) begin
         s1_addr_ff    <= req_addr;
         s1_mag_ff     <= req_mag;
         s1_fwd_val_ff <= s1_new;
      end
      if (tick_look) begin
         curve_ff <= LOG_CURVE[pend_peak[PEAK_W-1 -: LOG_IDX_W]];
      end
      if (tick_calc) begin
         rsp_chan_ff  <= CHAN_W'(tick_ch_ff);
         rsp_level_ff <= new_level;
         rsp_fresh_ff <= pend_vld_ff;
         rsp_last_ff  <= tick_last;
      end
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_channel   = rsp_chan_ff;
   assign rsp_display_level = rsp_level_ff;
   assign rsp_fresh         = rsp_fresh_ff;
   assign rsp_last          = rsp_last_ff;

`ifndef SYNTH
   // No request beat is taken while a result beat is on offer.
   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request side open while a result is pending");

   // Forwarding only follows a peak write in the previous cycle.
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      s1_fwd_ff |-> $past(s1_vld_ff))
      else $error("peak forwarding without a preceding write");

   // The pending flag clears only when the final beat of a tick is taken.
   a_pend_clear: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(pend_vld_ff)) |->
         $past(rsp_valid && !rsp_stall && rsp_last))
      else $error("pending snapshot dropped outside a tick");

   // A fresh result requires a pending snapshot.
   a_fresh_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fresh) |-> pend_vld_ff)
      else $error("fresh level without a pending snapshot");
`endif

endmodule
